[rtl/rgb_to_hsv_pixel_assert.svh]
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: assertion macros
// Shorthand for the clocked, reset-qualified properties used in the RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTH_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rth_pkg.sv]
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: shared definitions
// Field widths, hue scaling constants and the maximum-channel codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rth_pkg;

   localparam int ALPHA_W  = 8;
   localparam int HUE_W    = 15;
   localparam int SAT_W    = 8;
   localparam int BRIGHT_W = 8;

   localparam int DEGREES_PER_SECTOR = 60;
   localparam int SECTORS            = 6;

   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;

endpackage

[rtl/rth_if.sv]
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: stream interfaces
// Valid/ready channels for the RGBA pixel input and the HSV result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rth_req_if #(
   parameter int CHANNEL_BITS = 8
) ();
   logic                        valid;
   logic                        ready;
   logic [CHANNEL_BITS-1:0]     red;
   logic [CHANNEL_BITS-1:0]     green;
   logic [CHANNEL_BITS-1:0]     blue;
   logic [rth_pkg::ALPHA_W-1:0] alpha_in;

   modport source (output valid, output red, output green, output blue,
                   output alpha_in, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input alpha_in, output ready);
endinterface

interface rth_rsp_if ();
   logic                         valid;
   logic                         ready;
   logic [rth_pkg::HUE_W-1:0]    hue;
   logic [rth_pkg::SAT_W-1:0]    saturation;
   logic [rth_pkg::BRIGHT_W-1:0] brightness;
   logic [rth_pkg::ALPHA_W-1:0]  alpha_out;

   modport source (output valid, output hue, output saturation,
                   output brightness, output alpha_out, input ready);
   modport sink   (input valid, input hue, input saturation,
                   input brightness, input alpha_out, output ready);
endinterface

[rtl/rgb_to_hsv_pixel.sv]
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter
// Converts one RGBA pixel a transfer into hue, saturation, value and alpha.
// ----------------------------------------------------------------------------
// Pixels arrive on req_chan and results leave on rsp_chan, both valid/ready
// channels; a transfer happens on a clock edge with valid and ready high.
// One pixel can be taken every clock while rsp_chan.ready stays high, so the
// sustained rate is one pixel a cycle when the receiver does not stall. The
// hue and saturation quotients are NSTEP bits wide, where NSTEP is the larger
// of CHANNEL_BITS and the bit width of the sixty-degree hue step. They come
// from two restoring dividers, which retire one quotient bit per stage.
// Hue is in units of 1/(2^HUE_FRACTION_BITS) degree, saturation uses the
// full channel code for 1.0 and brightness is the largest channel.
// Each stage holds its pixel until the next stage is free, so a stalled
// receiver backs the pipeline up stage by stage and bubbles are squeezed
// out; nothing is lost or repeated. The block keeps no other state.
// Reset clears the stage valid flags only; the pipeline is empty afterwards
// and ready is high in the following cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_to_hsv_pixel_assert.svh"

module rgb_to_hsv_pixel #(
   parameter int CHANNEL_BITS      = 8,
   parameter int HUE_FRACTION_BITS = 6
) (
   input logic       clock,
   input logic       reset,
   rth_req_if.sink   req_chan,
   rth_rsp_if.source rsp_chan
);

   localparam int CB         = CHANNEL_BITS;
   localparam int SIXTY      = rth_pkg::DEGREES_PER_SECTOR * (2 ** HUE_FRACTION_BITS);
   localparam int SIXTY_BITS = $clog2(SIXTY + 1);
   localparam int NSTEP      = (SIXTY_BITS > CB) ? SIXTY_BITS : CB;
   localparam int NUM_W      = CB + NSTEP;
   localparam int TURN       = rth_pkg::SECTORS * SIXTY;
   localparam int HCW        = $clog2(TURN + 1);
   localparam int HOW        = (HCW > rth_pkg::HUE_W) ? HCW : rth_pkg::HUE_W;
   localparam int LAST       = NSTEP + 2;
   localparam int ALPHA_W    = rth_pkg::ALPHA_W;
   localparam int HUE_W      = rth_pkg::HUE_W;
   localparam int SAT_W      = rth_pkg::SAT_W;
   localparam int BRIGHT_W   = rth_pkg::BRIGHT_W;

   typedef struct packed {
      logic [CB-1:0]      mx;
      logic [CB-1:0]      delta;
      logic [CB-1:0]      absdiff;
      logic               neg;
      logic [1:0]         sel;
      logic [ALPHA_W-1:0] alpha;
   } front_type;

   typedef struct packed {
      logic [CB-1:0]      h_rem;
      logic [NSTEP-1:0]   h_lq;
      logic [CB-1:0]      h_div;
      logic [CB-1:0]      s_rem;
      logic [NSTEP-1:0]   s_lq;
      logic [CB-1:0]      s_div;
      logic               neg;
      logic [1:0]         sel;
      logic [CB-1:0]      bright;
      logic [ALPHA_W-1:0] alpha;
   } div_type;

   typedef struct packed {
      logic [HUE_W-1:0]    hue;
      logic [SAT_W-1:0]    sat;
      logic [BRIGHT_W-1:0] bright;
      logic [ALPHA_W-1:0]  alpha;
   } out_type;

   // One restoring step: bring in the next dividend bit, subtract if it fits,
   // and shift the new quotient bit in behind the remaining dividend bits.
   function automatic logic [NUM_W-1:0] div_step(input logic [CB-1:0]    rem,
                                                 input logic [NSTEP-1:0] lq,
                                                 input logic [CB-1:0]    dv);
      logic [CB:0] trial;
      logic [CB:0] diffv;
      logic        ge;
      trial = {rem, lq[NSTEP-1]};
      diffv = trial - {1'b0, dv};
      ge    = (trial >= {1'b0, dv});
      if (ge) begin
         return {diffv[CB-1:0], lq[NSTEP-2:0], 1'b1};
      end
      return {trial[CB-1:0], lq[NSTEP-2:0], 1'b0};
   endfunction

   logic [LAST:0]   v_ff;
   logic [LAST:0]   v_in;
   logic [LAST+1:0] adv;

   front_type front_ff;
   front_type front_in;
   div_type   div_ff [0:NSTEP];
   div_type   div_in [0:NSTEP];
   out_type   out_ff;
   out_type   out_in;

   logic [NUM_W-1:0] h_num;
   logic [NUM_W-1:0] s_num;
   logic [HOW-1:0]   hue_wide;
   logic [NSTEP-1:0] q_h;

   // Handshake: a stage may load when it is empty or its own content moves on.
   always_comb begin
      adv[LAST+1] = rsp_chan.ready;
      for (int i = LAST; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign req_chan.ready = adv[0];

   always_comb begin
      v_in[0] = adv[0] ? req_chan.valid : v_ff[0];
      for (int i = 1; i <= LAST; i++) begin
         v_in[i] = adv[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Stage 0: largest and smallest channel and the signed channel difference.
   always_comb begin
      logic [CB-1:0] mx;
      logic [CB-1:0] mn;
      logic [CB-1:0] pa;
      logic [CB-1:0] pb;
      logic [1:0]    sel;
      mx  = req_chan.red;
      sel = rth_pkg::SEL_RED;
      if (req_chan.green > mx) begin
         mx  = req_chan.green;
         sel = rth_pkg::SEL_GREEN;
      end
      if (req_chan.blue > mx) begin
         mx  = req_chan.blue;
         sel = rth_pkg::SEL_BLUE;
      end
      mn = req_chan.red;
      if (req_chan.green < mn) begin
         mn = req_chan.green;
      end
      if (req_chan.blue < mn) begin
         mn = req_chan.blue;
      end
      case (sel)
         rth_pkg::SEL_GREEN: begin
            pa = req_chan.blue;
            pb = req_chan.red;
         end
         rth_pkg::SEL_BLUE: begin
            pa = req_chan.red;
            pb = req_chan.green;
         end
         default: begin
            pa = req_chan.green;
            pb = req_chan.blue;
         end
      endcase
      front_in.mx      = mx;
      front_in.delta   = mx - mn;
      front_in.neg     = (pa < pb);
      front_in.absdiff = (pa < pb) ? (pb - pa) : (pa - pb);
      front_in.sel     = sel;
      front_in.alpha   = req_chan.alpha_in;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         front_ff <= front_in;
      end
   end

   // Stage 1: form both dividends and split them into remainder and low bits.
   always_comb begin
      h_num = NUM_W'(SIXTY) * NUM_W'(front_ff.absdiff);
      s_num = (NUM_W'(front_ff.delta) << CB) - NUM_W'(front_ff.delta);
      div_in[0].h_rem  = h_num[NUM_W-1:NSTEP];
      div_in[0].h_lq   = h_num[NSTEP-1:0];
      div_in[0].h_div  = front_ff.delta;
      div_in[0].s_rem  = s_num[NUM_W-1:NSTEP];
      div_in[0].s_lq   = s_num[NSTEP-1:0];
      div_in[0].s_div  = front_ff.mx;
      div_in[0].neg    = front_ff.neg;
      div_in[0].sel    = front_ff.sel;
      div_in[0].bright = front_ff.mx;
      div_in[0].alpha  = front_ff.alpha;
   end

   // Divider stages: one quotient bit for hue and saturation in each.
   for (genvar k = 1; k <= NSTEP; k++) begin : g_div_step
      always_comb begin
         div_in[k] = div_ff[k-1];
         {div_in[k].h_rem, div_in[k].h_lq} =
            div_step(div_ff[k-1].h_rem, div_ff[k-1].h_lq, div_ff[k-1].h_div);
         {div_in[k].s_rem, div_in[k].s_lq} =
            div_step(div_ff[k-1].s_rem, div_ff[k-1].s_lq, div_ff[k-1].s_div);
      end
   end

   for (genvar k = 0; k <= NSTEP; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (adv[k+1]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // Final stage: apply the sign and the sector offset, then wrap a negative
   // red hue by one full turn.
   assign q_h = div_ff[NSTEP].h_lq;

   always_comb begin
      hue_wide = '0;
      if (div_ff[NSTEP].h_div != '0) begin
         case (div_ff[NSTEP].sel)
            rth_pkg::SEL_RED: begin
               if (div_ff[NSTEP].neg && (q_h != '0)) begin
                  hue_wide = HOW'(TURN) - HOW'(q_h);
               end else begin
                  hue_wide = HOW'(q_h);
               end
            end
            rth_pkg::SEL_GREEN: begin
               hue_wide = div_ff[NSTEP].neg ? (HOW'(2 * SIXTY) - HOW'(q_h))
                                            : (HOW'(2 * SIXTY) + HOW'(q_h));
            end
            rth_pkg::SEL_BLUE: begin
               hue_wide = div_ff[NSTEP].neg ? (HOW'(4 * SIXTY) - HOW'(q_h))
                                            : (HOW'(4 * SIXTY) + HOW'(q_h));
            end
            default: begin
               hue_wide = '0;
            end
         endcase
      end
      out_in.hue    = hue_wide[HUE_W-1:0];
      out_in.sat    = (div_ff[NSTEP].s_div == '0) ? '0 : SAT_W'(div_ff[NSTEP].s_lq);
      out_in.bright = BRIGHT_W'(div_ff[NSTEP].bright);
      out_in.alpha  = div_ff[NSTEP].alpha;
   end

   always_ff @(posedge clock) begin
      if (adv[LAST]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid      = v_ff[LAST];
   assign rsp_chan.hue        = out_ff.hue;
   assign rsp_chan.saturation = out_ff.sat;
   assign rsp_chan.brightness = out_ff.bright;
   assign rsp_chan.alpha_out  = out_ff.alpha;

   `RTH_ASSERT_NEXT(a_transfer_fills_front, clock, reset,
                    req_chan.valid && req_chan.ready, v_ff[0],
                    "An input transfer did not reach the first stage.")
   `RTH_ASSERT_SAME(a_hue_rem_below_divisor, clock, reset,
                    v_ff[NSTEP+1] && (div_ff[NSTEP].h_div != '0),
                    div_ff[NSTEP].h_rem < div_ff[NSTEP].h_div,
                    "Hue division left a remainder not below the divisor.")
   `RTH_ASSERT_SAME(a_sat_rem_below_divisor, clock, reset,
                    v_ff[NSTEP+1] && (div_ff[NSTEP].s_div != '0),
                    div_ff[NSTEP].s_rem < div_ff[NSTEP].s_div,
                    "Saturation division left a remainder not below the divisor.")
   `RTH_ASSERT_SAME(a_hue_below_turn, clock, reset,
                    v_ff[NSTEP+1], hue_wide < HOW'(TURN),
                    "Hue reached a full turn.")
   `RTH_ASSERT_NEXT(a_stalled_result_held, clock, reset,
                    v_ff[LAST] && !rsp_chan.ready, v_ff[LAST] && $stable(out_ff),
                    "A stalled result was not held.")

endmodule
